### design/lsp_pkg.sv
// Shared types and constants for the LED substrip pixel router.
`timescale 1ns / 1ps

package lsp_pkg;

    localparam int TABLE_SLOTS = 4;
    localparam int SLOT_W      = 2;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int POS_W       = 10;
    localparam int COLOR_W     = 24;
    localparam int LEN_W       = 16;
    localparam int SUM_W       = 18;
    localparam int SID_W       = 2;
    localparam int USED_W      = 3;

    localparam logic [COLOR_W-1:0] FULL_WHITE = 24'hFF_FFFF;

    typedef enum logic [2:0] {
        REG_BRIGHTNESS = 3'd0,
        REG_REVERSE    = 3'd1,
        REG_ACTIVE     = 3'd2,
        REG_SUB0       = 3'd3,
        REG_SUB1       = 3'd4,
        REG_SUB2       = 3'd5,
        REG_SUB3       = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [SID_W-1:0] sid;
        logic             rev;
        logic [LEN_W-1:0] count;
        logic [LEN_W-1:0] start;
    } t_substrip;

    localparam int SUB_W = $bits(t_substrip);

endpackage

### design/led_substrip_pixel_router.sv
// Top level: pipelined pixel router with its APB register file.
`timescale 1ns / 1ps

// Usage
//   Input: drive i_pixel_position and i_pixel_color with start high for one
//   cycle per pixel. busy is always low, so a pixel can be issued every cycle.
//   Output: o_strobe marks a result for exactly one cycle; found, strip
//   select, LED index and the scaled colour are on the o_ ports with it.
//   Throughput is one pixel per clock. The four register stages are: prefix
//   sums of the substrip lengths, range check and global reversal,
//   substrip search with the brightness multiplies, final index and
//   strip id check.
//   Configuration goes through the APB port (64-bit data, register i at byte
//   address 8*i); write only while no pixel is in flight. pready is tied high.
//   Reset (synchronous, active low) empties the pipeline and returns the
//   registers to full brightness, no reversal and no active substrips.
//   The receiver cannot stall: a result not taken in its strobe cycle is lost.
module led_substrip_pixel_router #(
    parameter int MAX_SUBSTRIPS = 4,
    parameter int MAX_LEDS      = 1024,
    parameter int NUM_STRIPS    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        start,
    output logic                        busy,
    input  logic [lsp_pkg::POS_W-1:0]   i_pixel_position,
    input  logic [lsp_pkg::COLOR_W-1:0] i_pixel_color,
    // result channel
    output logic                        o_strobe,
    output logic                        o_found,
    output logic [lsp_pkg::SID_W-1:0]   o_strip_select,
    output logic [lsp_pkg::LEN_W-1:0]   o_physical_index,
    output logic [7:0]                  o_red_out,
    output logic [7:0]                  o_green_out,
    output logic [7:0]                  o_blue_out,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsp_pkg::ADDR_W-1:0]  paddr,
    input  logic [lsp_pkg::DATA_W-1:0]  pwdata,
    output logic [lsp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int LIM = (MAX_SUBSTRIPS < lsp_pkg::TABLE_SLOTS) ?
                         MAX_SUBSTRIPS : lsp_pkg::TABLE_SLOTS;
    localparam int SW  = lsp_pkg::SUM_W;
    localparam int LW  = lsp_pkg::LEN_W;
    localparam int NT  = lsp_pkg::TABLE_SLOTS;

    // ---------------- register file ----------------
    logic [lsp_pkg::COLOR_W-1:0] r_brightness;
    logic                        r_reverse;
    logic [lsp_pkg::USED_W-1:0]  r_active;
    lsp_pkg::t_substrip          r_sub [NT];

    lsp_pkg::t_reg_idx          w_reg;
    logic [lsp_pkg::SLOT_W-1:0] w_slot;
    logic                       w_wr;

    assign w_reg  = lsp_pkg::t_reg_idx'(paddr[5:3]);
    assign w_slot = lsp_pkg::SLOT_W'(paddr[5:3] - 3'(lsp_pkg::REG_SUB0));
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= lsp_pkg::FULL_WHITE;
            r_reverse    <= 1'b0;
            r_active     <= '0;
            for (int i = 0; i < NT; i++) begin
                r_sub[i] <= '0;
            end
        end else if (w_wr) begin
            case (w_reg)
                lsp_pkg::REG_BRIGHTNESS: r_brightness <= pwdata[lsp_pkg::COLOR_W-1:0];
                lsp_pkg::REG_REVERSE:    r_reverse    <= pwdata[0];
                lsp_pkg::REG_ACTIVE:     r_active     <= pwdata[lsp_pkg::USED_W-1:0];
                lsp_pkg::REG_SUB0, lsp_pkg::REG_SUB1,
                lsp_pkg::REG_SUB2, lsp_pkg::REG_SUB3: begin
                    r_sub[w_slot] <= lsp_pkg::t_substrip'(pwdata[lsp_pkg::SUB_W-1:0]);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_reg)
            lsp_pkg::REG_BRIGHTNESS: prdata = lsp_pkg::DATA_W'(r_brightness);
            lsp_pkg::REG_REVERSE:    prdata = lsp_pkg::DATA_W'(r_reverse);
            lsp_pkg::REG_ACTIVE:     prdata = lsp_pkg::DATA_W'(r_active);
            lsp_pkg::REG_SUB0, lsp_pkg::REG_SUB1,
            lsp_pkg::REG_SUB2, lsp_pkg::REG_SUB3: begin
                prdata = lsp_pkg::DATA_W'(r_sub[w_slot]);
            end
            default: prdata = '0;
        endcase
    end

    // ---------------- stage 1: prefix sums ----------------
    logic                        w_accept;
    logic [lsp_pkg::USED_W-1:0]  w_used;
    logic [SW-1:0]               n_pfx [NT];

    assign w_accept = start && !busy;
    assign w_used   = (r_active > lsp_pkg::USED_W'(LIM)) ? lsp_pkg::USED_W'(LIM) : r_active;

    // unused slots count as zero length, so they never match
    always_comb begin
        logic [SW-1:0] acc;
        acc = '0;
        for (int i = 0; i < NT; i++) begin
            if (lsp_pkg::USED_W'(i) < w_used) begin
                acc = acc + SW'(r_sub[i].count);
            end
            n_pfx[i] = acc;
        end
    end

    logic                        r_v1;
    logic [lsp_pkg::POS_W-1:0]   r_s1_pos;
    logic [lsp_pkg::COLOR_W-1:0] r_s1_color;
    logic [SW-1:0]               r_s1_pfx [NT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
        end
        r_s1_pos   <= i_pixel_position;
        r_s1_color <= i_pixel_color;
        for (int i = 0; i < NT; i++) begin
            r_s1_pfx[i] <= n_pfx[i];
        end
    end

    // ---------------- stage 2: range check and reversal ----------------
    logic          n_in_range;
    logic [SW-1:0] n_idx;
    logic [SW-1:0] w_pos_ext;

    assign w_pos_ext  = SW'(r_s1_pos);
    assign n_in_range = (w_pos_ext < r_s1_pfx[NT-1]) &&
                        (17'(r_s1_pos) < 17'(MAX_LEDS));
    assign n_idx      = r_reverse ? (r_s1_pfx[NT-1] - SW'(1) - w_pos_ext) : w_pos_ext;

    logic                        r_v2;
    logic                        r_s2_in_range;
    logic [SW-1:0]               r_s2_idx;
    logic [lsp_pkg::COLOR_W-1:0] r_s2_color;
    logic [SW-1:0]               r_s2_pfx [NT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_s2_in_range <= n_in_range;
        r_s2_idx      <= n_idx;
        r_s2_color    <= r_s1_color;
        for (int i = 0; i < NT; i++) begin
            r_s2_pfx[i] <= r_s1_pfx[i];
        end
    end

    // ---------------- stage 3: substrip search and scaling ----------------
    logic                       n_hit;
    logic [lsp_pkg::SLOT_W-1:0] n_sel;
    logic [LW-1:0]              n_local;
    logic [15:0]                w_prod_r, w_prod_g, w_prod_b;

    // first slot whose running total exceeds the index
    always_comb begin
        logic [SW-1:0] base;
        n_hit   = 1'b0;
        n_sel   = '0;
        n_local = '0;
        base    = '0;
        for (int i = 0; i < NT; i++) begin
            if (!n_hit && (r_s2_idx < r_s2_pfx[i])) begin
                n_hit   = 1'b1;
                n_sel   = lsp_pkg::SLOT_W'(i);
                n_local = LW'(r_s2_idx - base);
            end
            base = r_s2_pfx[i];
        end
        n_hit = n_hit && r_s2_in_range;
    end

    assign w_prod_r = r_s2_color[23:16] * r_brightness[23:16];
    assign w_prod_g = r_s2_color[15:8]  * r_brightness[15:8];
    assign w_prod_b = r_s2_color[7:0]   * r_brightness[7:0];

    logic                       r_v3;
    logic                       r_s3_hit;
    logic [lsp_pkg::SLOT_W-1:0] r_s3_sel;
    logic [LW-1:0]              r_s3_local;
    logic [7:0]                 r_s3_red, r_s3_green, r_s3_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_s3_hit   <= n_hit;
        r_s3_sel   <= n_sel;
        r_s3_local <= n_local;
        r_s3_red   <= w_prod_r[15:8];
        r_s3_green <= w_prod_g[15:8];
        r_s3_blue  <= w_prod_b[15:8];
    end

    // ---------------- stage 4: LED index and strip check ----------------
    lsp_pkg::t_substrip w_ent;
    logic [LW-1:0]      w_off;
    logic               n_found;

    assign w_ent   = r_sub[r_s3_sel];
    assign w_off   = w_ent.rev ? (w_ent.count - LW'(1) - r_s3_local) : r_s3_local;
    assign n_found = r_s3_hit && (3'(w_ent.sid) < 3'(NUM_STRIPS));

    logic                      r_v4;
    logic                      r_s4_found;
    logic [lsp_pkg::SID_W-1:0] r_s4_sid;
    logic [LW-1:0]             r_s4_index;
    logic [7:0]                r_s4_red, r_s4_green, r_s4_blue;

    // drop the payload to zero when the pixel is not routed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_s4_found <= n_found;
        r_s4_sid   <= n_found ? w_ent.sid : '0;
        r_s4_index <= n_found ? (w_off + w_ent.start) : '0;
        r_s4_red   <= n_found ? r_s3_red : '0;
        r_s4_green <= n_found ? r_s3_green : '0;
        r_s4_blue  <= n_found ? r_s3_blue : '0;
    end

    assign o_strobe         = r_v4;
    assign o_found          = r_s4_found;
    assign o_strip_select   = r_s4_sid;
    assign o_physical_index = r_s4_index;
    assign o_red_out        = r_s4_red;
    assign o_green_out      = r_s4_green;
    assign o_blue_out       = r_s4_blue;

    // ---------------- assertions ----------------
    a_strobe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, 4))
        else $error("result beat without a pixel four cycles earlier");

    a_zero_when_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> (o_strip_select == '0 && o_physical_index == '0 &&
                                    o_red_out == '0 && o_green_out == '0 &&
                                    o_blue_out == '0))
        else $error("unrouted pixel carries a non-zero payload");

    a_strip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_found) |-> (3'(o_strip_select) < 3'(NUM_STRIPS)))
        else $error("routed pixel to a strip that does not exist");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_found) |-> (17'($past(i_pixel_position, 4)) < 17'(MAX_LEDS)))
        else $error("routed a pixel beyond the LED limit");

    a_hit_in_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_s3_hit) |-> (r_s3_local < r_sub[r_s3_sel].count))
        else $error("offset lies outside the selected substrip");

endmodule

### tb/tb_led_substrip_pixel_router.sv
// Self-checking testbench for the LED substrip pixel router: APB set-up, pixel stream, scoreboard.
`timescale 1ns / 1ps

module tb_led_substrip_pixel_router;

    localparam int MAX_SUBSTRIPS = 4;
    localparam int MAX_LEDS      = 1024;
    localparam int NUM_STRIPS    = 4;
    localparam int LATENCY       = 4;
    localparam int PHASES        = 12;
    localparam int PHASE_PIXELS  = 112;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int UNMAPPED_REG  = int'(lsp_pkg::REG_SUB3) + 1;

    typedef struct packed {
        logic                        found;
        logic [lsp_pkg::SID_W-1:0]   strip;
        logic [lsp_pkg::LEN_W-1:0]   led;
        logic [7:0]                  red;
        logic [7:0]                  green;
        logic [7:0]                  blue;
    } t_pixel_route;

    class t_route_checker;
        logic [lsp_pkg::COLOR_W-1:0] brightness;
        logic                        reverse_all;
        logic [lsp_pkg::USED_W-1:0]  active;
        lsp_pkg::t_substrip          strips[lsp_pkg::TABLE_SLOTS];
        t_pixel_route                routed_q[$];
        int                          errors;
        int                          pixels;
        int                          routed;
        int                          settings;

        function new();
            brightness  = lsp_pkg::FULL_WHITE;
            reverse_all = 1'b0;
            active      = '0;
            foreach (strips[i]) strips[i] = '0;
        endfunction

        // unknown indexes are dropped, spare bits masked off
        function void set_reg(int unsigned idx, logic [63:0] value);
            case (idx)
                lsp_pkg::REG_BRIGHTNESS: brightness  = value[lsp_pkg::COLOR_W-1:0];
                lsp_pkg::REG_REVERSE:    reverse_all = value[0];
                lsp_pkg::REG_ACTIVE:     active      = value[lsp_pkg::USED_W-1:0];
                lsp_pkg::REG_SUB0, lsp_pkg::REG_SUB1, lsp_pkg::REG_SUB2, lsp_pkg::REG_SUB3:
                    strips[idx - int'(lsp_pkg::REG_SUB0)] = value[lsp_pkg::SUB_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned used_strips();
            return (active > MAX_SUBSTRIPS) ? MAX_SUBSTRIPS : active;
        endfunction

        function int unsigned total_len();
            int unsigned sum;
            sum = 0;
            for (int i = 0; i < used_strips(); i++) sum += strips[i].count;
            return sum;
        endfunction

        function logic [7:0] scale(logic [7:0] c, logic [7:0] b);
            logic [15:0] prod;
            prod = c * b;
            return prod[15:8];
        endfunction

        function void note_pixel(logic [lsp_pkg::POS_W-1:0] pos,
                                 logic [lsp_pkg::COLOR_W-1:0] color);
            t_pixel_route want;
            int unsigned  total;
            int unsigned  idx;
            int unsigned  off;
            bit           hit;
            want  = '0;
            hit   = 1'b0;
            total = total_len();
            if (pos < total && pos < MAX_LEDS) begin
                idx = reverse_all ? total - 1 - pos : pos;
                for (int i = 0; i < used_strips() && !hit; i++) begin
                    if (idx < strips[i].count) begin
                        hit = 1'b1;
                        off = strips[i].rev ? strips[i].count - 1 - idx : idx;
                        // a strip id past the last strip drops the pixel
                        if (strips[i].sid < NUM_STRIPS) begin
                            want.found = 1'b1;
                            want.strip = strips[i].sid;
                            want.led   = lsp_pkg::LEN_W'(off + strips[i].start);
                            want.red   = scale(color[23:16], brightness[23:16]);
                            want.green = scale(color[15:8], brightness[15:8]);
                            want.blue  = scale(color[7:0], brightness[7:0]);
                        end
                    end else begin
                        idx -= strips[i].count;
                    end
                end
            end
            pixels++;
            if (want.found) routed++;
            routed_q.push_back(want);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task cmp_field(string name, logic [lsp_pkg::LEN_W-1:0] got,
                       logic [lsp_pkg::LEN_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(t_pixel_route got);
            t_pixel_route want;
            if (routed_q.size() == 0) begin
                report("result beat with no pixel outstanding");
                return;
            end
            want = routed_q.pop_front();
            cmp_field("found", lsp_pkg::LEN_W'(got.found), lsp_pkg::LEN_W'(want.found));
            cmp_field("strip_select", lsp_pkg::LEN_W'(got.strip), lsp_pkg::LEN_W'(want.strip));
            cmp_field("physical_index", got.led, want.led);
            cmp_field("red_out", lsp_pkg::LEN_W'(got.red), lsp_pkg::LEN_W'(want.red));
            cmp_field("green_out", lsp_pkg::LEN_W'(got.green), lsp_pkg::LEN_W'(want.green));
            cmp_field("blue_out", lsp_pkg::LEN_W'(got.blue), lsp_pkg::LEN_W'(want.blue));
        endtask
    endclass

    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         start            = 1'b0;
    logic                         busy;
    logic [lsp_pkg::POS_W-1:0]    i_pixel_position = '0;
    logic [lsp_pkg::COLOR_W-1:0]  i_pixel_color    = '0;
    logic                         o_strobe;
    logic                         o_found;
    logic [lsp_pkg::SID_W-1:0]    o_strip_select;
    logic [lsp_pkg::LEN_W-1:0]    o_physical_index;
    logic [7:0]                   o_red_out;
    logic [7:0]                   o_green_out;
    logic [7:0]                   o_blue_out;
    logic                         psel             = 1'b0;
    logic                         penable          = 1'b0;
    logic                         pwrite           = 1'b0;
    logic [lsp_pkg::ADDR_W-1:0]   paddr            = '0;
    logic [lsp_pkg::DATA_W-1:0]   pwdata           = '0;
    logic [lsp_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    int                           cycles           = 0;
    int                           idle_modes[4]    = '{0, 75, 0, 38};

    t_route_checker sb = new();

    led_substrip_pixel_router dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_pixel_position (i_pixel_position),
        .i_pixel_color    (i_pixel_color),
        .o_strobe         (o_strobe),
        .o_found          (o_found),
        .o_strip_select   (o_strip_select),
        .o_physical_index (o_physical_index),
        .o_red_out        (o_red_out),
        .o_green_out      (o_green_out),
        .o_blue_out       (o_blue_out),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.routed_q.size());
            $display("tb_led_substrip_pixel_router: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_pixel(i_pixel_position, i_pixel_color);
            if (o_strobe)
                sb.check_result({o_found, o_strip_select, o_physical_index,
                                 o_red_out, o_green_out, o_blue_out});
        end
    end

    task write_reg(int unsigned idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lsp_pkg::ADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // junk above the field checks the register masking
    function logic [63:0] strip_word(logic [15:0] first, logic [15:0] len, logic rev,
                                     logic [1:0] id);
        return {29'($urandom), id, rev, len, first};
    endfunction

    task write_scalars(logic [23:0] bright, logic rev, logic [2:0] act);
        write_reg(lsp_pkg::REG_BRIGHTNESS, {$urandom, 8'($urandom), bright});
        write_reg(lsp_pkg::REG_REVERSE, {$urandom, 31'($urandom), rev});
        write_reg(lsp_pkg::REG_ACTIVE, {$urandom, 29'($urandom), act});
        sb.settings++;
    endtask

    task send_pixel(logic [lsp_pkg::POS_W-1:0] pos, logic [lsp_pkg::COLOR_W-1:0] color,
                    int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start            <= 1'b1;
        i_pixel_position <= pos;
        i_pixel_color    <= color;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // drop start, let the pipeline empty before touching registers
    task settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.routed_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task random_config();
        int unsigned sel;
        logic [23:0] bright;
        logic [15:0] len;
        sel    = $urandom_range(0, 3);
        bright = (sel == 0) ? 24'h0 : (sel == 1) ? lsp_pkg::FULL_WHITE : 24'($urandom);
        sel    = $urandom_range(0, 9);
        write_scalars(bright, 1'($urandom),
                      (sel < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7)));
        for (int i = 0; i < lsp_pkg::TABLE_SLOTS; i++) begin
            sel = $urandom_range(0, 9);
            len = (sel == 0) ? 16'h0 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(1, 400));
            write_reg(int'(lsp_pkg::REG_SUB0) + i,
                      strip_word(16'($urandom), len, 1'($urandom), 2'($urandom)));
        end
    endtask

    initial begin
        int unsigned total;
        logic [lsp_pkg::POS_W-1:0] pos;
        logic [lsp_pkg::COLOR_W-1:0] color;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // out of reset no substrip is active, so nothing routes
        send_pixel(10'd0, lsp_pkg::FULL_WHITE, 0);
        send_pixel(10'd1023, 24'h123456, 0);
        settle();

        // wrap past 0xFFFF, a reversed strip, an empty strip, a long tail
        write_scalars(24'hFF8001, 1'b0, 3'd4);
        write_reg(lsp_pkg::REG_SUB0, strip_word(16'hFFFE, 16'd5, 1'b0, 2'd1));
        write_reg(lsp_pkg::REG_SUB1, strip_word(16'd100, 16'd3, 1'b1, 2'd2));
        write_reg(lsp_pkg::REG_SUB2, strip_word(16'd7, 16'd0, 1'b0, 2'd3));
        write_reg(lsp_pkg::REG_SUB3, strip_word(16'd0, 16'd1000, 1'b1, 2'd0));
        send_pixel(10'd0, lsp_pkg::FULL_WHITE, 0);
        send_pixel(10'd4, 24'h000000, 0);
        send_pixel(10'd5, 24'h800080, 0);
        send_pixel(10'd7, lsp_pkg::FULL_WHITE, 0);
        send_pixel(10'd8, 24'h00FF00, 0);
        send_pixel(10'd1007, 24'hFF0000, 0);
        send_pixel(10'd1008, lsp_pkg::FULL_WHITE, 0);
        send_pixel(10'd1023, lsp_pkg::FULL_WHITE, 0);
        settle();

        // global reversal, count above the table size, zero brightness
        write_scalars(24'h000000, 1'b1, 3'd7);
        write_reg(UNMAPPED_REG, {$urandom, $urandom});
        send_pixel(10'd0, lsp_pkg::FULL_WHITE, 0);
        send_pixel(10'd1007, lsp_pkg::FULL_WHITE, 0);
        send_pixel(10'd1008, lsp_pkg::FULL_WHITE, 0);
        send_pixel(10'd1023, lsp_pkg::FULL_WHITE, 0);
        send_pixel(10'd512, 24'h5A5A5A, 0);
        settle();

        // one full-length reversed strip on the last strip id
        write_scalars(lsp_pkg::FULL_WHITE, 1'b0, 3'd1);
        write_reg(lsp_pkg::REG_SUB0, strip_word(16'hFFFF, 16'hFFFF, 1'b1, 2'd3));
        send_pixel(10'd0, lsp_pkg::FULL_WHITE, 0);
        send_pixel(10'd1023, 24'hA5C3E1, 0);
        send_pixel(10'd300, 24'h010203, 0);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            random_config();
            total = sb.total_len();
            for (int k = 0; k < PHASE_PIXELS; k++) begin
                // mostly positions that land inside the strips
                if (total != 0 && $urandom_range(0, 9) < 8)
                    pos = lsp_pkg::POS_W'($urandom_range(0,
                              ((total < MAX_LEDS) ? total : MAX_LEDS) - 1));
                else
                    pos = lsp_pkg::POS_W'($urandom);
                case ($urandom_range(0, 9))
                    0:       color = 24'h000000;
                    1:       color = lsp_pkg::FULL_WHITE;
                    default: color = 24'($urandom);
                endcase
                send_pixel(pos, color, idle_modes[p % 4]);
            end
            settle();
        end

        $display("summary: %0d pixels checked over %0d register settings", sb.pixels, sb.settings);
        $display("summary: %0d routed to a strip, %0d dropped", sb.routed, sb.pixels - sb.routed);
        if (sb.errors == 0)
            $display("tb_led_substrip_pixel_router: done, clean");
        else
            $display("tb_led_substrip_pixel_router: done, errors");
        $finish;
    end

endmodule

### sim.f
design/lsp_pkg.sv
design/led_substrip_pixel_router.sv
tb/tb_led_substrip_pixel_router.sv
